>>> rtl/ritoa_pkg.sv
// Shared types, constants and helpers for the radix integer-to-ASCII converter.
// No dependencies.
`default_nettype none

package ritoa_pkg;

    localparam int BITS_PER_STEP = 8;
    localparam int VALUE_W       = 32;
    localparam int RADIX_W       = 8;
    localparam int CHAR_W        = 8;
    localparam int DIGIT_W       = 4;
    localparam int BASE_W        = 5;

    localparam logic [CHAR_W-1:0]  CHAR_ZERO    = 8'h30;
    localparam logic [CHAR_W-1:0]  CHAR_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0]  CHAR_NONE    = 8'h00;
    localparam logic [DIGIT_W-1:0] DIGIT_NINE   = 4'd9;
    localparam logic [DIGIT_W-1:0] DIGIT_TEN    = 4'd10;
    localparam logic [RADIX_W-1:0] RADIX_MIN    = 8'd2;
    localparam logic [RADIX_W-1:0] RADIX_MAX    = 8'd16;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic err;
        logic step;
        logic step_last;
        logic rd;
    } t_cmd;

    typedef struct packed {
        logic radix_ok;
        logic quot_nz;
        logic rd_last;
    } t_stat;

    function automatic logic [CHAR_W-1:0] ascii_of(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        if (d <= DIGIT_NINE) begin
            c = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, d};
        end else begin
            c = CHAR_LOWER_A + {{(CHAR_W-DIGIT_W){1'b0}}, d - DIGIT_TEN};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

>>> rtl/ritoa_ctrl.sv
// Sequencer for the converter: accepts a transaction, runs the division passes
// and the character read-out. Depends on ritoa_pkg.
`default_nettype none

module ritoa_ctrl import ritoa_pkg::*; #(
    parameter int STEPS = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_start,
    input  wire t_stat i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    localparam int SW = (STEPS > 1) ? $clog2(STEPS) : 1;
    localparam logic [SW-1:0] STEP_END = SW'(STEPS - 1);
    localparam logic [SW-1:0] STEP_ONE = SW'(1);

    t_state          r_state, n_state;
    logic [SW-1:0]   r_step, n_step;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        o_cmd   = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    if (i_stat.radix_ok) begin
                        o_cmd.load = 1'b1;
                        n_step     = '0;
                        n_state    = ST_DIVIDE;
                    end else begin
                        o_cmd.err = 1'b1;
                    end
                end
            end
            ST_DIVIDE: begin
                o_cmd.step = 1'b1;
                if (r_step == STEP_END) begin
                    o_cmd.step_last = 1'b1;
                    n_step          = '0;
                    if (!i_stat.quot_nz) begin
                        n_state = ST_EMIT;
                    end
                end else begin
                    n_step = r_step + STEP_ONE;
                end
            end
            ST_EMIT: begin
                o_cmd.rd = 1'b1;
                if (i_stat.rd_last) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_busy = (r_state != ST_IDLE);

endmodule

`default_nettype wire

>>> rtl/ritoa_dpath.sv
// Datapath: 8-bit-per-cycle restoring divider by the radix, digit store and
// character output register. Depends on ritoa_pkg.
`default_nettype none

module ritoa_dpath import ritoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [RADIX_W-1:0] i_radix,
    input  wire t_cmd               i_cmd,
    output t_stat                   o_stat,
    output logic                    o_strobe,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last,
    output logic                    o_bad_radix
);

    localparam int QB    = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int STEPS = (QB + BITS_PER_STEP - 1) / BITS_PER_STEP;
    localparam int QW    = STEPS * BITS_PER_STEP;
    localparam int AW    = $clog2(MAX_DIGITS);
    localparam int CW    = $clog2(MAX_DIGITS + 1);
    localparam logic [AW-1:0] ADDR_END = AW'(MAX_DIGITS - 1);
    localparam logic [AW-1:0] ADDR_ONE = AW'(1);
    localparam logic [CW-1:0] CNT_MAX  = CW'(MAX_DIGITS);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    logic [QW-1:0]       r_quot;
    logic [BASE_W-1:0]   r_base;
    logic [DIGIT_W-1:0]  r_rem;
    logic                r_qnz;
    logic [AW-1:0]       r_wp;
    logic [AW-1:0]       r_rp;
    logic [CW-1:0]       r_cnt;
    logic [CW-1:0]       r_left;
    logic [DIGIT_W-1:0]  r_rdata;
    logic                r_strobe;
    logic                r_last;
    logic                r_bad;
    logic [DIGIT_W-1:0]  mem_digit [MAX_DIGITS];

    logic [QW-1:0]       s_quot;
    logic [DIGIT_W-1:0]  s_rem;
    logic [BASE_W-1:0]   s_trial;
    logic [CW-1:0]       n_cnt;
    logic [AW-1:0]       n_wp;
    logic [AW-1:0]       n_rp;

    // one byte of the dividend per cycle, MSB first
    always_comb begin
        s_rem  = r_rem;
        s_quot = r_quot;
        for (int i = 0; i < BITS_PER_STEP; i++) begin
            s_trial = {s_rem, s_quot[QW-1]};
            s_quot  = {s_quot[QW-2:0], 1'b0};
            if (s_trial >= r_base) begin
                s_rem     = DIGIT_W'(s_trial - r_base);
                s_quot[0] = 1'b1;
            end else begin
                s_rem = s_trial[DIGIT_W-1:0];
            end
        end
    end

    assign n_cnt = (r_cnt == CNT_MAX) ? r_cnt : r_cnt + CNT_ONE;
    assign n_wp  = (r_wp == ADDR_END) ? '0 : r_wp + ADDR_ONE;
    assign n_rp  = (r_rp == '0) ? ADDR_END : r_rp - ADDR_ONE;

    assign o_stat.radix_ok = (i_radix >= RADIX_MIN) && (i_radix <= RADIX_MAX);
    assign o_stat.quot_nz  = r_qnz | (|s_quot[BITS_PER_STEP-1:0]);
    assign o_stat.rd_last  = (r_left == CNT_ONE);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_quot <= QW'(i_value[QB-1:0]);
            r_base <= i_radix[BASE_W-1:0];
            r_rem  <= '0;
            r_qnz  <= 1'b0;
            r_wp   <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.step) begin
            r_quot <= s_quot;
            if (i_cmd.step_last) begin
                r_rem  <= '0;
                r_qnz  <= 1'b0;
                r_rp   <= r_wp;
                r_wp   <= n_wp;
                r_cnt  <= n_cnt;
                r_left <= n_cnt;
            end else begin
                r_rem <= s_rem;
                r_qnz <= o_stat.quot_nz;
            end
        end else if (i_cmd.rd) begin
            r_rp   <= n_rp;
            r_left <= r_left - CNT_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.step && i_cmd.step_last) begin
            mem_digit[r_wp] <= s_rem;
        end
        if (i_cmd.rd) begin
            r_rdata <= mem_digit[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.rd | i_cmd.err;
        end
    end

    always_ff @(posedge i_clk) begin
        r_last <= i_cmd.err | o_stat.rd_last;
        r_bad  <= i_cmd.err;
    end

    assign o_strobe    = r_strobe;
    assign o_last      = r_last;
    assign o_bad_radix = r_bad;
    assign o_character = r_bad ? CHAR_NONE : ascii_of(r_rdata);

endmodule

`default_nettype wire

>>> rtl/radix_integer_to_ascii_core.sv
// Top level of the radix integer-to-ASCII converter: sequencer plus datapath.
// Depends on ritoa_pkg, ritoa_ctrl, ritoa_dpath.
//
// Usage:
//   A transaction is taken at a rising edge with start high and busy low;
//   i_value and i_radix are sampled then. Characters come out most
//   significant first, one per cycle, each valid for exactly one cycle while
//   o_strobe is high; o_last marks the final one. The receiver cannot stall.
//   A radix outside 2..16 gives a single result (character 0, o_last and
//   o_bad_radix high) in the next cycle, and busy stays low.
// Operation (S = ceil(min(VALUE_WIDTH,32)/8) dividend bytes, 4 by default):
//   Each digit takes one pass over the S-byte quotient in the shared 8-bit-per-cycle
//   divider; once every digit is formed, the digit store is read one
//   character a cycle, most significant first.
//   busy falls as the last character goes out, so the next transaction can
//   follow at once.
// Reset: synchronous, active low; returns to idle and drops o_strobe.
`default_nettype none

module radix_integer_to_ascii_core import ritoa_pkg::*; #(
    parameter int VALUE_WIDTH = 32,
    parameter int MAX_DIGITS  = 32
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic [VALUE_W-1:0] i_value,
    input  wire logic [RADIX_W-1:0] i_radix,
    output logic                    o_strobe,
    output logic [CHAR_W-1:0]       o_character,
    output logic                    o_last,
    output logic                    o_bad_radix
);

    localparam int QB    = (VALUE_WIDTH < VALUE_W) ? VALUE_WIDTH : VALUE_W;
    localparam int STEPS = (QB + BITS_PER_STEP - 1) / BITS_PER_STEP;

    t_cmd  s_cmd;
    t_stat s_stat;

    ritoa_ctrl #(
        .STEPS (STEPS)
    ) u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (s_stat),
        .o_cmd   (s_cmd),
        .o_busy  (busy)
    );

    ritoa_dpath #(
        .VALUE_WIDTH (VALUE_WIDTH),
        .MAX_DIGITS  (MAX_DIGITS)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .i_cmd       (s_cmd),
        .o_stat      (s_stat),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

endmodule

`default_nettype wire

>>> rtl/ritoa_checker.sv
// Port-level checks for radix_integer_to_ascii_core, bound to the top level.
// Depends on ritoa_pkg.
`default_nettype none

module ritoa_checker import ritoa_pkg::*; (
    input wire logic               i_clk,
    input wire logic               i_rst_n,
    input wire logic               start,
    input wire logic               busy,
    input wire logic [RADIX_W-1:0] i_radix,
    input wire logic               o_strobe,
    input wire logic [CHAR_W-1:0]  o_character,
    input wire logic               o_last,
    input wire logic               o_bad_radix
);

    logic s_take;
    logic s_radix_ok;

    assign s_take     = start && !busy;
    assign s_radix_ok = (i_radix >= RADIX_MIN) && (i_radix <= RADIX_MAX);

    a_bad_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_bad_radix) |-> (o_last && (o_character == CHAR_NONE)))
        else $error("bad radix result malformed");

    a_digit_char: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_bad_radix) |->
            ((o_character >= 8'h30 && o_character <= 8'h39) ||
             (o_character >= 8'h61 && o_character <= 8'h66)))
        else $error("character is not a digit");

    a_bad_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && !s_radix_ok) |=> (o_strobe && o_bad_radix && !busy))
        else $error("bad radix not reported next cycle");

    a_good_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_take && s_radix_ok) |=> (busy && !o_strobe))
        else $error("valid transaction did not start conversion");

    a_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |=> o_strobe)
        else $error("gap inside a character burst");

endmodule

bind radix_integer_to_ascii_core ritoa_checker u_ritoa_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_radix     (i_radix),
    .o_strobe    (o_strobe),
    .o_character (o_character),
    .o_last      (o_last),
    .o_bad_radix (o_bad_radix)
);

`default_nettype wire

>>> tb/sv/radix_integer_to_ascii_core_test.sv
// Self-checking testbench for radix_integer_to_ascii_core: directed and random values and
// radixes, each converted to ASCII digits by a predictor and checked character by character.
// Depends on ritoa_pkg and the RTL of radix_integer_to_ascii_core.
`timescale 1ns / 1ps

module radix_integer_to_ascii_core_test import ritoa_pkg::*; ();

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 170;
    localparam int RANDOM_ITEMS   = 420;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
        logic              bad_radix;
    } t_text_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               start = 1'b0;
    logic [VALUE_W-1:0] i_value = '0;
    logic [RADIX_W-1:0] i_radix = '0;
    logic               busy;
    logic               o_strobe;
    logic [CHAR_W-1:0]  o_character;
    logic               o_last;
    logic               o_bad_radix;

    t_text_char  pending_chars[$];
    t_text_char  got_char;
    t_text_char  want_char;
    int unsigned mismatches = 0;
    int unsigned values_sent = 0;
    int unsigned bad_radix_sent = 0;
    int unsigned chars_checked = 0;
    int unsigned idle_cycles = 0;

    radix_integer_to_ascii_core DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_value     (i_value),
        .i_radix     (i_radix),
        .o_strobe    (o_strobe),
        .o_character (o_character),
        .o_last      (o_last),
        .o_bad_radix (o_bad_radix)
    );

    always #2 i_clk = ~i_clk;

    // Expected text of one value: digits most significant first, or a single error mark.
    task automatic predict_text(input logic [VALUE_W-1:0] value,
                                input logic [RADIX_W-1:0] radix);
        logic [DIGIT_W-1:0] digits[32];
        logic [VALUE_W-1:0] quotient;
        t_text_char         c;
        int                 n;
        if (radix < RADIX_MIN || radix > RADIX_MAX) begin
            c.character = CHAR_NONE;
            c.last      = 1'b1;
            c.bad_radix = 1'b1;
            pending_chars.push_back(c);
            bad_radix_sent++;
            return;
        end
        quotient = value;
        n = 0;
        do begin
            digits[n] = DIGIT_W'(quotient % radix);
            quotient  = quotient / radix;
            n++;
        end while (quotient != 0);
        for (int k = n - 1; k >= 0; k--) begin
            if (digits[k] <= DIGIT_NINE) begin
                c.character = CHAR_ZERO + CHAR_W'(digits[k]);
            end else begin
                c.character = CHAR_LOWER_A + CHAR_W'(digits[k] - DIGIT_TEN);
            end
            c.last      = (k == 0);
            c.bad_radix = 1'b0;
            pending_chars.push_back(c);
        end
    endtask

    task automatic send_value(input logic [VALUE_W-1:0] value,
                              input logic [RADIX_W-1:0] radix,
                              input int unsigned gap);
        if (!start) begin
            start <= 1'b1;
        end
        i_value <= value;
        i_radix <= radix;
        do @(posedge i_clk); while (busy !== 1'b0);
        predict_text(value, radix);
        values_sent++;
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            return 0;
        end else if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    // Values around powers of the radix, where the digit count changes.
    function automatic logic [VALUE_W-1:0] boundary_value(input int unsigned radix);
        logic [63:0] p;
        int unsigned steps;
        int unsigned k;
        steps = $urandom_range(1, 32);
        p = 64'd1;
        for (k = 0; k < steps && p * radix <= 64'hffff_ffff; k++) begin
            p = p * radix;
        end
        case ($urandom_range(0, 2))
            0: return VALUE_W'(p - 1);
            1: return VALUE_W'(p);
            default: return VALUE_W'(p + 1);
        endcase
    endfunction

    task automatic test_extremes();
        send_value('0, 8'd2, pick_gap());
        send_value('0, 8'd16, 0);
        send_value(32'hffff_ffff, 8'd2, pick_gap());
        send_value(32'hffff_ffff, 8'd3, 0);
        send_value(32'hffff_ffff, 8'd10, pick_gap());
        send_value(32'hfedc_ba98, 8'd16, 0);
        send_value(32'd10, 8'd11, pick_gap());
    endtask

    task automatic test_bad_radix();
        send_value(32'd12345, 8'd0, 0);
        send_value(32'hffff_ffff, 8'd1, 0);
        send_value('0, 8'd17, 0);
        send_value(32'h8000_0001, 8'd255, 0);
        send_value(32'd7, 8'd128, pick_gap());
    endtask

    task automatic test_each_radix();
        for (int unsigned r = RADIX_MIN; r <= RADIX_MAX; r++) begin
            send_value($urandom, RADIX_W'(r), (r % 2 == 0) ? 0 : pick_gap());
        end
    endtask

    task automatic test_random();
        logic [RADIX_W-1:0] radix;
        logic [VALUE_W-1:0] value;
        logic               no_gaps;
        int unsigned        gap;
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i % 30 == 0) begin
                no_gaps = ($urandom_range(0, 2) == 0);
            end
            if ($urandom_range(0, 99) < 15) begin
                radix = RADIX_W'($urandom_range(0, 255));
                while (radix >= RADIX_MIN && radix <= RADIX_MAX) begin
                    radix = RADIX_W'($urandom_range(0, 255));
                end
            end else begin
                radix = RADIX_W'($urandom_range(RADIX_MIN, RADIX_MAX));
            end
            case ($urandom_range(0, 9))
                0, 1, 2, 3: value = $urandom;
                4, 5:       value = $urandom_range(0, 300);
                6, 7, 8:    value = boundary_value(radix < RADIX_MIN ? 2 : radix);
                default:    value = $urandom_range(0, 1) ? 32'hffff_ffff : '0;
            endcase
            gap = no_gaps ? 0 : pick_gap();
            send_value(value, radix, gap);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe !== 1'b0) begin
            got_char = '{character: o_character, last: o_last, bad_radix: o_bad_radix};
            if (pending_chars.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("unexpected character: char=%h last=%b bad_radix=%b",
                             o_character, o_last, o_bad_radix);
                end
            end else begin
                want_char = pending_chars.pop_front();
                chars_checked++;
                if (got_char !== want_char) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display({"mismatch: expected char=%h last=%b bad_radix=%b,",
                                  " got char=%h last=%b bad_radix=%b"},
                                 want_char.character, want_char.last, want_char.bad_radix,
                                 o_character, o_last, o_bad_radix);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if ((start && busy === 1'b0) || o_strobe === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
            $display("radix_integer_to_ascii_core_test: errors");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_extremes();
        test_bad_radix();
        test_each_radix();
        test_random();
        if (start) begin
            start <= 1'b0;
        end
        while (pending_chars.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d values (%0d with bad radix), %0d characters checked",
                 values_sent, bad_radix_sent, chars_checked);
        $display("mismatches: %0d", mismatches);
        if (mismatches == 0) begin
            $display("radix_integer_to_ascii_core_test: clean");
        end else begin
            $display("radix_integer_to_ascii_core_test: errors");
        end
        $finish;
    end

endmodule
